### hw/rtl/abe_pkg.sv
// Shared types, codes and helpers for the arithmetic encoder bitstream block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package abe_pkg;

   // Request operation codes, carried on req_tuser.
   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   // Result status codes, carried on rsp_tuser.
   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_BAD = 2'd1;
   localparam logic [1:0] STATUS_OVF = 2'd2;

   // Kinds of work handed from the front end to the back end.
   localparam logic [1:0] KIND_ENCODE = 2'd0;
   localparam logic [1:0] KIND_BAD    = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   // Maximum precision and the reset value of the precision register.
   localparam logic [4:0] PREC_MAX   = 5'd30;
   localparam logic [4:0] PREC_RESET = 5'd24;

   // Width of a cumulative count.
   localparam int COUNT_WIDTH = 31;

   // Depth of the queue between front and back ends.
   localparam int QUEUE_DEPTH = 2;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic [1:0] kind;
      count_type  cum_low;
      count_type  cum_upper;
   } abe_entry_type;

   // Precision values above the maximum act as the maximum.
   function automatic logic [4:0] clamp_prec(input logic [4:0] prec);
      return (prec > PREC_MAX) ? PREC_MAX : prec;
   endfunction

   // Cumulative frequency total for a clamped precision.
   function automatic count_type prec_total(input logic [4:0] prec);
      return count_type'(1) << prec;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/arithmetic_encoder_bitstream.sv
// Top level of the arithmetic encoder bitstream block: precision register and wiring.
// Depends on abe_pkg, abe_front, abe_queue and abe_back.
//
//   Channel  Direction  Transaction carries
//   req_     in         tuser: operation; tdata: cum_low, cum_upper
//   rsp_     out        tdata: out_byte; tlast: last_in_run; tuser: status
//   csr_     in         wdata: precision_bits
//
// An encode widens the interval, multiplies, narrows, then shifts out the emitted
// prefix bits one bit per cycle unless rsp_ stalls. A finish flushes the active
// bits and pads the last byte; a rejected item yields a single error result.
// Reset is synchronous and clears the coder; precision returns to 24.
// The two-entry queue lets requests be taken while the back end or rsp_ stalls.
`default_nettype none

module arithmetic_encoder_bitstream
   import abe_pkg::*;
#(
   parameter int STATE_WIDTH = 64
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // cum_low [30:0], cum_upper [61:31]
   input  wire logic [0:0]  req_tuser,   // operation [0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_byte [7:0]
   output logic             rsp_tlast,
   output logic [1:0]       rsp_tuser,   // status [1:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [4:0]  csr_wdata
);

   logic [4:0]    prec_ff, prec_in;
   logic [4:0]    prec_eff;
   logic          push_valid;
   logic          push_ready;
   abe_entry_type push_entry;
   logic          pop_valid;
   logic          pop;
   abe_entry_type pop_entry;

   // Precision register, written by a csr transaction.
   assign csr_ready = 1'b1;
   assign prec_in   = (csr_valid && csr_ready) ? csr_wdata : prec_ff;
   assign prec_eff  = clamp_prec(prec_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         prec_ff <= PREC_RESET;
      end else begin
         prec_ff <= prec_in;
      end
   end

   abe_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .prec       (prec_eff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   abe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   abe_back #(
      .STATE_WIDTH (STATE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .prec       (prec_eff),
      .q_valid    (pop_valid),
      .q_entry    (pop_entry),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

### hw/rtl/abe_front.sv
// Front end: takes request transactions and classifies them for the back end.
// Depends on abe_pkg for the entry type and the operation and kind codes.
`default_nettype none

module abe_front
   import abe_pkg::*;
(
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [63:0]   req_tdata,   // cum_low [30:0], cum_upper [61:31]
   input  wire logic [0:0]    req_tuser,   // operation [0]
   input  wire logic [4:0]    prec,
   output logic               push_valid,
   input  wire logic          push_ready,
   output abe_entry_type      push_entry
);

   count_type cum_low;
   count_type cum_upper;
   count_type total;
   logic      counts_bad;

   assign cum_low   = req_tdata[COUNT_WIDTH-1:0];
   assign cum_upper = req_tdata[2*COUNT_WIDTH-1:COUNT_WIDTH];
   assign total     = prec_total(prec);

   // A symbol of zero width, out of order, or past the total is rejected.
   assign counts_bad = (cum_low >= cum_upper) || (cum_upper > total);

   // Classify the transaction while handing it to the queue.
   always_comb begin
      push_entry.cum_low   = cum_low;
      push_entry.cum_upper = cum_upper;
      priority if (req_tuser[0] == OP_FINISH) begin
         push_entry.kind = KIND_FINISH;
      end else if (counts_bad) begin
         push_entry.kind = KIND_BAD;
      end else begin
         push_entry.kind = KIND_ENCODE;
      end
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

`default_nettype wire

### hw/rtl/abe_queue.sv
// Short queue of classified work between the front and back ends.
// Depends on abe_pkg for the entry type and the queue depth.
`default_nettype none

module abe_queue
   import abe_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   output logic               push_ready,
   input  wire abe_entry_type push_entry,
   output logic               pop_valid,
   input  wire logic          pop,
   output abe_entry_type      pop_entry
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   abe_entry_type  entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push;
   logic           do_pop;

   assign push_ready = (count_ff < CW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // The fill count never passes the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("queue fill count above depth");

endmodule

`default_nettype wire

### hw/rtl/abe_back.sv
// Back end: interval arithmetic, renormalization, bit packing and result output.
// Depends on abe_pkg for the entry type, kind and status codes and helpers.
`default_nettype none

module abe_back
   import abe_pkg::*;
#(
   parameter int STATE_WIDTH = 64
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [4:0]    prec,
   input  wire logic          q_valid,
   input  wire abe_entry_type q_entry,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [7:0]         rsp_tdata,   // out_byte [7:0]
   output logic               rsp_tlast,
   output logic [1:0]         rsp_tuser    // status [1:0]
);

   localparam int SW = STATE_WIDTH;
   localparam int TW = $clog2(STATE_WIDTH + 1);
   localparam int IW = $clog2(STATE_WIDTH);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_WIDEN  = 4'd1;
   localparam logic [3:0] ST_MUL_HI = 4'd2;
   localparam logic [3:0] ST_MUL_LO = 4'd3;
   localparam logic [3:0] ST_NARROW = 4'd4;
   localparam logic [3:0] ST_EMIT   = 4'd5;
   localparam logic [3:0] ST_FLUSH  = 4'd6;
   localparam logic [3:0] ST_PAD    = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [SW-1:0] lo_ff, lo_in;
   logic [SW-1:0] hi_ff, hi_in;
   logic [TW-1:0] tcnt_ff, tcnt_in;        // active bit count, top index plus one
   logic [SW-1:0] save_lo_ff, save_lo_in;
   logic [SW-1:0] save_hi_ff, save_hi_in;
   logic [TW-1:0] save_tcnt_ff, save_tcnt_in;
   count_type     cl_ff, cl_in;
   count_type     ch_ff, ch_in;
   logic [31:0]   rng_ff, rng_in;
   logic [62:0]   prod_ff, prod_in;
   logic [7:0]    pend_bits_ff, pend_bits_in;
   logic [2:0]    pend_cnt_ff, pend_cnt_in;
   logic          hold_valid_ff, hold_valid_in;
   logic [7:0]    hold_byte_ff, hold_byte_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   logic [TW-1:0] tcnt_dec;
   logic [IW-1:0] idx;
   logic [SW-1:0] idx_mask;
   count_type     total;
   logic [SW-1:0] diff;
   logic [31:0]   width_cur;
   count_type     mul_b;
   logic [31:0]   quot;
   logic          out_free;
   logic          put_req;
   logic          put_bit;
   logic          pad_req;
   logic [7:0]    bits_set;
   logic          byte_done;
   logic [7:0]    byte_val;
   logic          stall;

   assign tcnt_dec  = tcnt_ff - TW'(1);
   assign idx       = tcnt_dec[IW-1:0];
   assign idx_mask  = SW'(1) << idx;
   assign total     = prec_total(prec);
   assign diff      = hi_ff - lo_ff;
   assign width_cur = diff[31:0] + 32'd1;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // One shared multiplier: the high count first, then the low count.
   assign mul_b   = (state_ff == ST_MUL_HI) ? ch_ff : cl_ff;
   assign prod_in = 63'(rng_ff) * 63'(mul_b);
   assign quot    = prod_ff[62:31] == '0 ? prod_ff[31:0] >> prec : 32'(prod_ff >> prec);

   // Which bit, if any, goes into the packer this cycle.
   always_comb begin
      put_req = 1'b0;
      put_bit = 1'b0;
      pad_req = 1'b0;
      unique case (state_ff)
         ST_EMIT: begin
            if ((tcnt_ff != '0) && (lo_ff[idx] == hi_ff[idx])) begin
               put_req = 1'b1;
               put_bit = lo_ff[idx];
            end
         end
         ST_FLUSH: begin
            if (tcnt_ff != '0) begin
               put_req = 1'b1;
               put_bit = lo_ff[idx];
            end
         end
         ST_PAD: begin
            pad_req = (pend_cnt_ff != 3'd0);
         end
         default: begin
            put_req = 1'b0;
         end
      endcase
   end

   // A completed byte is held until the next one shows it was not last or the item ends.
   assign bits_set  = pend_bits_ff | (8'(put_bit) << pend_cnt_ff);
   assign byte_done = (put_req && (pend_cnt_ff == 3'd7)) || pad_req;
   assign byte_val  = pad_req ? pend_bits_ff : bits_set;
   assign stall     = byte_done && hold_valid_ff && !out_free;

   // Sequencer for one item.
   always_comb begin
      state_in      = state_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      tcnt_in       = tcnt_ff;
      save_lo_in    = save_lo_ff;
      save_hi_in    = save_hi_ff;
      save_tcnt_in  = save_tcnt_ff;
      cl_in         = cl_ff;
      ch_in         = ch_ff;
      rng_in        = rng_ff;
      pend_bits_in  = pend_bits_ff;
      pend_cnt_in   = pend_cnt_ff;
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      q_pop         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_entry.kind)
                  KIND_BAD: begin
                     if (out_free) begin
                        q_pop         = 1'b1;
                        rsp_valid_in  = 1'b1;
                        rsp_byte_in   = 8'd0;
                        rsp_last_in   = 1'b1;
                        rsp_status_in = STATUS_BAD;
                     end
                  end
                  KIND_FINISH: begin
                     q_pop    = 1'b1;
                     state_in = ST_FLUSH;
                  end
                  default: begin
                     q_pop        = 1'b1;
                     save_lo_in   = lo_ff;
                     save_hi_in   = hi_ff;
                     save_tcnt_in = tcnt_ff;
                     cl_in        = q_entry.cum_low;
                     ch_in        = q_entry.cum_upper;
                     state_in     = ST_WIDEN;
                  end
               endcase
            end
         end
         ST_WIDEN: begin
            if (width_cur < {1'b0, total}) begin
               if (hi_ff[SW-1]) begin
                  // Growth past the state width: report and keep the old state.
                  if (out_free) begin
                     lo_in         = save_lo_ff;
                     hi_in         = save_hi_ff;
                     tcnt_in       = save_tcnt_ff;
                     rsp_valid_in  = 1'b1;
                     rsp_byte_in   = 8'd0;
                     rsp_last_in   = 1'b1;
                     rsp_status_in = STATUS_OVF;
                     state_in      = ST_IDLE;
                  end
               end else begin
                  lo_in   = {lo_ff[SW-2:0], 1'b0};
                  hi_in   = {hi_ff[SW-2:0], 1'b1};
                  tcnt_in = tcnt_ff + TW'(1);
               end
            end else begin
               rng_in   = width_cur;
               state_in = ST_MUL_HI;
            end
         end
         ST_MUL_HI: begin
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            hi_in    = lo_ff + SW'(quot) - SW'(1);
            state_in = ST_NARROW;
         end
         ST_NARROW: begin
            lo_in    = lo_ff + SW'(quot);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Shift out the leading bits common to both bounds.
            if (put_req) begin
               if (!stall) begin
                  lo_in   = lo_ff & ~idx_mask;
                  hi_in   = hi_ff & ~idx_mask;
                  tcnt_in = tcnt_dec;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FLUSH: begin
            // Emit every active bit of the low bound, top bit first.
            if (put_req) begin
               if (!stall) begin
                  tcnt_in = tcnt_dec;
               end
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (!stall) begin
               lo_in        = '0;
               hi_in        = '0;
               tcnt_in      = '0;
               pend_bits_in = 8'd0;
               pend_cnt_in  = 3'd0;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            // The held byte, if any, is the last result of the item.
            if (hold_valid_ff) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_byte_in   = hold_byte_ff;
                  rsp_last_in   = 1'b1;
                  rsp_status_in = STATUS_OK;
                  hold_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Bit packer, least significant bit first.
      if (put_req && !stall) begin
         if (pend_cnt_ff == 3'd7) begin
            pend_bits_in = 8'd0;
            pend_cnt_in  = 3'd0;
         end else begin
            pend_bits_in = bits_set;
            pend_cnt_in  = pend_cnt_ff + 3'd1;
         end
      end

      // A new byte pushes any held byte out as a non-final result.
      if (byte_done && !stall) begin
         if (hold_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_byte_in   = hold_byte_ff;
            rsp_last_in   = 1'b0;
            rsp_status_in = STATUS_OK;
         end
         hold_valid_in = 1'b1;
         hold_byte_in  = byte_val;
      end
   end

   // Control and coder state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lo_ff         <= '0;
         hi_ff         <= '0;
         tcnt_ff       <= '0;
         pend_bits_ff  <= 8'd0;
         pend_cnt_ff   <= 3'd0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lo_ff         <= lo_in;
         hi_ff         <= hi_in;
         tcnt_ff       <= tcnt_in;
         pend_bits_ff  <= pend_bits_in;
         pend_cnt_ff   <= pend_cnt_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      save_lo_ff    <= save_lo_in;
      save_hi_ff    <= save_hi_in;
      save_tcnt_ff  <= save_tcnt_in;
      cl_ff         <= cl_in;
      ch_ff         <= ch_in;
      rng_ff        <= rng_in;
      prod_ff       <= prod_in;
      hold_byte_ff  <= hold_byte_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

   // An error result stands alone and carries a zero byte.
   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != STATUS_OK)) |-> (rsp_tlast && (rsp_tdata == 8'd0)))
      else $error("error result not final or not zero");

   // No byte is left held once an item has completed.
   a_hold_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !hold_valid_ff)
      else $error("held byte left over between items");

   // The active bit count stays within the state width.
   a_tcnt_bound: assert property (@(posedge clock) disable iff (reset)
      tcnt_ff <= TW'(STATE_WIDTH))
      else $error("active bit count above state width");

endmodule

`default_nettype wire

### verif/tb_arithmetic_encoder_bitstream.sv
// Self-checking testbench for the arithmetic encoder bitstream block.
// Needs abe_pkg and arithmetic_encoder_bitstream; a built-in coder model predicts every byte.
`timescale 1ns / 100ps

module tb_arithmetic_encoder_bitstream;
   import abe_pkg::*;

   // One request transaction: operation on tuser, counts on tdata.
   typedef struct {
      logic            operation;
      logic [30:0]     cum_low;
      logic [30:0]     cum_upper;
   } symbol_req_type;

   // One result transaction: byte on tdata, end of run on tlast, status on tuser.
   typedef struct {
      logic [7:0]      out_byte;
      logic            last_in_run;
      logic [1:0]      status;
   } coded_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_wdata = '0;

   // Stimulus waiting to be sent, and bytes the coder model expects back.
   symbol_req_type pending_symbols[$];
   coded_byte_type expected_bytes[$];
   coded_byte_type step_bytes[$];

   // Coder model state.
   logic [4:0]  model_prec = PREC_RESET;
   logic [63:0] coder_low = '0;
   logic [63:0] coder_high = '0;
   int          coder_top = -1;
   logic [7:0]  pack_bits = '0;
   int          pack_count = 0;

   int             error_count = 0;
   bit             no_idle = 1'b0;
   int             send_gap = 0;
   int             take_stall = 0;
   symbol_req_type on_bus;
   coded_byte_type want;

   arithmetic_encoder_bitstream dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      error_count++;
   endtask

   // Idle lengths: mostly none or short, now and then long.
   function automatic int draw_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   task automatic push_byte(input logic [7:0] value, input logic [1:0] status);
      coded_byte_type entry;
      entry.out_byte = value;
      entry.last_in_run = 1'b0;
      entry.status = status;
      step_bytes = {step_bytes, entry};
   endtask

   // Appends one request to the stimulus queue.
   task automatic queue_symbol(input symbol_req_type sym);
      pending_symbols = {pending_symbols, sym};
   endtask

   // Bits fill the byte from bit 0 upward; a full byte becomes a result.
   task automatic shift_bit(input logic bit_val);
      pack_bits[pack_count] = bit_val;
      pack_count++;
      if (pack_count == 8) begin
         push_byte(pack_bits, STATUS_OK);
         pack_bits = '0;
         pack_count = 0;
      end
   endtask

   task automatic clear_coder();
      coder_low = '0;
      coder_high = '0;
      coder_top = -1;
      pack_bits = '0;
      pack_count = 0;
   endtask

   // Advance the coder model by one accepted request and queue the bytes it yields.
   task automatic predict_symbol(input symbol_req_type sym);
      logic [63:0] total, lo, hi, span, cl, ch, lead;
      int          top;
      logic        overflow;
      total = 64'd1 << ((model_prec > PREC_MAX) ? PREC_MAX : model_prec);
      step_bytes.delete();
      if (sym.operation == OP_FINISH) begin
         // Flush all active bits of the low bound, most significant first.
         while (coder_top >= 0) begin
            shift_bit(coder_low[coder_top]);
            coder_top--;
         end
         if (pack_count > 0)
            push_byte(pack_bits, STATUS_OK);
         clear_coder();
      end else begin
         cl = 64'(sym.cum_low);
         ch = 64'(sym.cum_upper);
         if (cl >= ch || ch > total) begin
            push_byte(8'h00, STATUS_BAD);
         end else begin
            // Widen until the interval spans the count total.
            lo = coder_low;
            hi = coder_high;
            top = coder_top;
            overflow = 1'b0;
            while (hi - lo + 64'd1 < total) begin
               if (hi[63]) begin
                  overflow = 1'b1;
                  break;
               end
               lo = lo << 1;
               hi = {hi[62:0], 1'b1};
               top++;
            end
            if (overflow) begin
               push_byte(8'h00, STATUS_OVF);
            end else begin
               // Narrow to the symbol, then shift out the shared leading bits.
               span = hi - lo + 64'd1;
               coder_low = lo + (span * cl) / total;
               coder_high = lo + (span * ch) / total - 64'd1;
               coder_top = top;
               while (coder_top >= 0) begin
                  lead = coder_low >> coder_top;
                  if (lead != (coder_high >> coder_top))
                     break;
                  coder_low = coder_low - (lead << coder_top);
                  coder_high = coder_high - (lead << coder_top);
                  coder_top--;
                  shift_bit(lead[0]);
               end
            end
         end
      end
      if (step_bytes.size() > 0)
         step_bytes[step_bytes.size() - 1].last_in_run = 1'b1;
      expected_bytes = {expected_bytes, step_bytes};
   endtask

   function automatic symbol_req_type make_symbol(input logic op, input logic [31:0] cl,
                                                  input logic [31:0] ch);
      symbol_req_type sym;
      sym.operation = op;
      sym.cum_low = cl[30:0];
      sym.cum_upper = ch[30:0];
      return sym;
   endfunction

   // Mostly well-formed symbols, some centered ones that keep the bounds straddling
   // a bit boundary, plus finishes, misordered counts and raw noise.
   function automatic symbol_req_type random_symbol(input logic [31:0] total);
      int unsigned pick;
      logic [31:0] cl, ch, widest;
      pick = $urandom_range(0, 99);
      cl = $urandom;
      ch = $urandom;
      if (pick < 8) begin
         return make_symbol(OP_FINISH, cl, ch);
      end else if (pick < 16) begin
         return make_symbol(OP_ENCODE, cl, ch);
      end else if (pick < 21) begin
         ch = $urandom_range(0, total);
         cl = $urandom_range(ch, total);
      end else if (pick < 33 && total >= 4) begin
         cl = total / 2 - 1;
         ch = total / 2 + 1;
      end else if (pick < 60) begin
         cl = $urandom_range(0, total - 1);
         widest = total - cl;
         if (widest > 16)
            widest = 16;
         ch = cl + $urandom_range(1, widest);
      end else begin
         cl = $urandom_range(0, total - 1);
         ch = $urandom_range(cl + 1, total);
      end
      return make_symbol(OP_ENCODE, cl, ch);
   endfunction

   // Driver: presents queued requests and feeds each accepted one to the model.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            predict_symbol(on_bus);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_symbols.size() > 0) begin
               on_bus = pending_symbols.pop_front();
               req_tuser <= on_bus.operation;
               req_tdata <= {2'b00, on_bus.cum_upper, on_bus.cum_low};
               req_tvalid <= 1'b1;
               send_gap = no_idle ? 0 : draw_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares every result transaction with the oldest expected byte.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         take_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               report_error($sformatf("unexpected result byte %02h last %0d status %0d",
                                      rsp_tdata, rsp_tlast, rsp_tuser));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.out_byte)
                  report_error($sformatf("out_byte %02h, expected %02h",
                                         rsp_tdata, want.out_byte));
               if (rsp_tlast !== want.last_in_run)
                  report_error($sformatf("last_in_run %0d, expected %0d",
                                         rsp_tlast, want.last_in_run));
               if (rsp_tuser !== want.status)
                  report_error($sformatf("status %0d, expected %0d",
                                         rsp_tuser, want.status));
            end
         end
         if (take_stall > 0) begin
            take_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 5) == 0)
               take_stall = draw_gap();
         end
      end
   end

   // Wait until everything sent has been answered, then allow for a silent item.
   task automatic wait_idle();
      @(posedge clock);
      while (pending_symbols.size() > 0 || req_tvalid || expected_bytes.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_precision(input logic [4:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      model_prec = value;
   endtask

   // One phase: new precision, its full-range edge symbols, random symbols, a finish.
   task automatic run_phase(input logic [4:0] prec, input int count);
      logic [31:0] total;
      wait_idle();
      write_precision(prec);
      no_idle = ($urandom_range(0, 3) == 0);
      total = 32'd1 << ((prec > PREC_MAX) ? PREC_MAX : prec);
      queue_symbol(make_symbol(OP_ENCODE, 32'd0, total));
      queue_symbol(make_symbol(OP_ENCODE, total - 1, total));
      repeat (count)
         queue_symbol(random_symbol(total));
      queue_symbol(make_symbol(OP_FINISH, $urandom, $urandom));
   endtask

   // Stimulus sequence.
   initial begin
      logic [31:0] full;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset precision.
      full = 32'd1 << PREC_RESET;
      queue_symbol(make_symbol(OP_FINISH, 32'd0, 32'd0));
      queue_symbol(make_symbol(OP_ENCODE, 32'd0, full));
      queue_symbol(make_symbol(OP_ENCODE, 32'd0, 32'd1));
      queue_symbol(make_symbol(OP_ENCODE, full - 1, full));
      queue_symbol(make_symbol(OP_ENCODE, 32'd5, 32'd5));
      queue_symbol(make_symbol(OP_ENCODE, 32'd9, 32'd3));
      queue_symbol(make_symbol(OP_ENCODE, 32'd0, full + 1));
      queue_symbol(make_symbol(OP_ENCODE, 32'h7fffffff, 32'h7fffffff));
      queue_symbol(make_symbol(OP_ENCODE, 32'd0, 32'h7fffffff));
      queue_symbol(make_symbol(OP_FINISH, 32'h7fffffff, 32'h7fffffff));
      // Centered symbols keep the bounds apart until widening runs out of room.
      repeat (5)
         queue_symbol(make_symbol(OP_ENCODE, full / 2 - 1, full / 2 + 1));
      queue_symbol(make_symbol(OP_ENCODE, 32'd3, 32'd4));
      queue_symbol(make_symbol(OP_FINISH, 32'd0, 32'd0));
      queue_symbol(make_symbol(OP_ENCODE, full / 3, full / 3 + 1));
      queue_symbol(make_symbol(OP_ENCODE, 32'd1, 32'd2));
      queue_symbol(make_symbol(OP_FINISH, $urandom, $urandom));

      // Random phases over several precisions, the extremes among them.
      run_phase(5'd0, 48);
      run_phase(5'd31, 48);
      run_phase(5'd1, 48);
      run_phase(5'd30, 48);
      run_phase(5'd2, 48);
      run_phase(5'd12, 48);
      run_phase(5'($urandom_range(3, 29)), 48);
      run_phase(5'($urandom_range(3, 29)), 48);
      run_phase(PREC_RESET, 48);

      wait_idle();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### files.f
hw/rtl/abe_pkg.sv
hw/rtl/abe_front.sv
hw/rtl/abe_queue.sv
hw/rtl/abe_back.sv
hw/rtl/arithmetic_encoder_bitstream.sv
verif/tb_arithmetic_encoder_bitstream.sv
